/* rtl/core/mts_pkg.sv */
`timescale 1ns / 1ps

package mts_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_READ = '1;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] data_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [1:0]               status;
  } out_t;

endpackage

/* rtl/core/min_tracking_stack.sv */
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data   (operation, data_value)
// out     | output    | out_valid / out_ready| out_data  (top_value, min_value,
//         |           |                      |            is_empty, status)
//
// query, push and error cases: result registered directly from the request
// pop: passes through S_POP, which waits on the synchronous read of the entries
//   below both stack tops
// both tops live in registers; the two memories hold every entry
// rst_n is synchronous, active low, and clears both counts (no memory clear)
// a request is taken while the previous result waits only if out_ready is high

module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t st_r, st_nxt;
  logic [CW-1:0] vcnt_r, vcnt_nxt;
  logic [CW-1:0] mcnt_r, mcnt_nxt;
  logic signed [DATA_W-1:0] top_r, top_nxt;
  logic signed [DATA_W-1:0] mtop_r, mtop_nxt;
  logic mpop_r, mpop_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic in_fire;
  logic out_free;
  logic v_we, m_we;
  logic signed [DATA_W-1:0] v_rdata, m_rdata;
  logic [CW-1:0] vcnt_dec2, mcnt_dec2;
  logic push_min;

  function automatic out_t make_res(
    input logic [CW-1:0]        vc,
    input logic [CW-1:0]        mc,
    input logic signed [DATA_W-1:0] top,
    input logic signed [DATA_W-1:0] mtop,
    input logic [1:0]           st
  );
    out_t r;
    r.top_value = (vc != '0) ? top : EMPTY_READ;
    r.min_value = (mc != '0) ? mtop : EMPTY_READ;
    r.is_empty  = (vc == '0);
    r.status    = st;
    return r;
  endfunction

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (st_r == S_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign vcnt_dec2 = vcnt_r - CW'(2);
  assign mcnt_dec2 = mcnt_r - CW'(2);
  assign push_min  = (mcnt_r == '0) || (in_data.data_value <= mtop_r);

  // write side is used only on push, read data only on pop, so no overlap
  assign v_we = in_fire && (in_data.operation == OP_PUSH) && (vcnt_r != FULL_CNT);
  assign m_we = v_we && push_min;

  mts_ram #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AW)
  ) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (vcnt_r[AW-1:0]),
    .wdata (in_data.data_value),
    .raddr (vcnt_dec2[AW-1:0]),
    .rdata (v_rdata)
  );

  mts_ram #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AW)
  ) u_min_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (mcnt_r[AW-1:0]),
    .wdata (in_data.data_value),
    .raddr (mcnt_dec2[AW-1:0]),
    .rdata (m_rdata)
  );

  always_comb begin
    st_nxt        = st_r;
    vcnt_nxt      = vcnt_r;
    mcnt_nxt      = mcnt_r;
    top_nxt       = top_r;
    mtop_nxt      = mtop_r;
    mpop_nxt      = mpop_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.operation)
            OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (vcnt_r == FULL_CNT) begin
                out_data_nxt = make_res(vcnt_r, mcnt_r, top_r, mtop_r, ST_FULL);
              end else begin
                vcnt_nxt = vcnt_r + CW'(1);
                top_nxt  = in_data.data_value;
                if (push_min) begin
                  mcnt_nxt = mcnt_r + CW'(1);
                  mtop_nxt = in_data.data_value;
                end
                out_data_nxt = make_res(vcnt_nxt, mcnt_nxt, top_nxt, mtop_nxt, ST_OK);
              end
            end
            OP_POP: begin
              if (vcnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = make_res(vcnt_r, mcnt_r, top_r, mtop_r, ST_EMPTY);
              end else begin
                // entries below both tops are being read this cycle
                mpop_nxt = (mcnt_r != '0) && (mtop_r == top_r);
                st_nxt   = S_POP;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = make_res(vcnt_r, mcnt_r, top_r, mtop_r, ST_OK);
            end
          endcase
        end
      end
      S_POP: begin
        vcnt_nxt = vcnt_r - CW'(1);
        top_nxt  = v_rdata;
        if (mpop_r) begin
          mcnt_nxt = mcnt_r - CW'(1);
          mtop_nxt = m_rdata;
        end
        out_valid_nxt = 1'b1;
        out_data_nxt  = make_res(vcnt_nxt, mcnt_nxt, top_nxt, mtop_nxt, ST_OK);
        st_nxt        = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      vcnt_r      <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      vcnt_r      <= vcnt_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    mtop_r     <= mtop_nxt;
    mpop_r     <= mpop_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_min_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= vcnt_r)
    else $error("minimum stack deeper than value stack");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= FULL_CNT)
    else $error("value count beyond stack depth");

  a_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.operation == OP_POP) && (vcnt_r != '0))
      |=> (st_r == S_POP) && !out_valid_r)
    else $error("pop did not enter read wait");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_POP) |=> out_valid_r && (vcnt_r == $past(vcnt_r) - CW'(1)))
    else $error("pop did not produce a result");
`endif

endmodule

/* rtl/core/mts_ram.sv */
`timescale 1ns / 1ps

module mts_ram
  import mts_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
